/* src/fca_pkg.sv */
`timescale 1ns / 1ps

package fca_pkg;

  // table geometry
  localparam int unsigned FAT_ENTRIES = 4096;
  localparam int unsigned FAT_AW      = $clog2(FAT_ENTRIES);
  localparam int unsigned CNT_W       = FAT_AW + 1;

  // field widths
  localparam int unsigned EW     = 12;
  localparam int unsigned SIZE_W = 32;
  localparam int unsigned CFG_W  = 13;
  localparam int unsigned SHF_W  = 4;

  localparam logic [EW-1:0] FAT_FREE = '0;
  localparam logic [EW-1:0] FAT_EOC  = 12'hFFF;

  localparam logic [CFG_W-1:0] ENTRY_COUNT_RST   = 13'd4096;
  localparam logic [SHF_W-1:0] CLUSTER_SHIFT_RST = 4'd9;

  // first table index that an allocation may hand out
  localparam logic [CNT_W-1:0] FIRST_DATA = CNT_W'(2);

  localparam logic STATUS_OK       = 1'b0;
  localparam logic STATUS_NO_SPACE = 1'b1;

  typedef enum logic [1:0] {
    FUNC_WRITE = 2'd0,
    FUNC_READ  = 2'd1,
    FUNC_ALLOC = 2'd2,
    FUNC_NONE  = 2'd3
  } func_e;

  typedef enum logic {
    CFG_ENTRY_COUNT   = 1'b0,
    CFG_CLUSTER_SHIFT = 1'b1
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_COUNT,
    ST_LINK
  } state_e;

endpackage

/* src/fat12_cluster_chain_allocator.sv */
`timescale 1ns / 1ps

// Channel   Ports                                         Handshake
// ------    --------------------------------------------  -------------------------------
// command   func_i, entry_index_i, entry_value_i,         taken when start & !busy
//           file_size_i
// result    read_value_o, first_cluster_o, status_o       one word per command, done_o
//                                                         high for exactly one cycle
// config    cfg_we_i, cfg_idx_i, cfg_wdata_i              written when cfg_we_i is high
//
// Timing: a write or an unused function code answers in the cycle after the command,
// a read once the table RAM word has been registered into the result. An allocate runs
// a counting sweep of (limit - 2) table reads, then a linking sweep up to the last free
// entry it takes, each at one entry per cycle over the single read port of the table
// RAM, and it ends with the end-of-chain write.
// Reset: the table RAM has no reset, so a clearing sweep writes zero to all
// 4096 entries, one per cycle, with busy held high; then the block goes idle.
// The receiver cannot stall: done_o marks the word for one cycle only.

module fat12_cluster_chain_allocator (
  input  logic                                clk_i,
  input  logic                                rst_ni,

  // command
  input  logic                                start,
  output logic                                busy,
  input  fca_pkg::func_e                      func_i,
  input  logic [fca_pkg::EW-1:0]              entry_index_i,
  input  logic [fca_pkg::EW-1:0]              entry_value_i,
  input  logic [fca_pkg::SIZE_W-1:0]          file_size_i,

  // result
  output logic                                done_o,
  output logic [fca_pkg::EW-1:0]              read_value_o,
  output logic [fca_pkg::EW-1:0]              first_cluster_o,
  output logic                                status_o,

  // configuration
  input  logic                                cfg_we_i,
  input  fca_pkg::cfg_idx_e                   cfg_idx_i,
  input  logic [fca_pkg::CFG_W-1:0]           cfg_wdata_i
);

  import fca_pkg::*;

  // configuration registers
  logic [CFG_W-1:0] entry_count_q;
  logic [SHF_W-1:0] cluster_shift_q;

  // control
  state_e            state_q, state_d;
  logic [FAT_AW-1:0] clr_q, clr_d;
  logic [CNT_W-1:0]  scan_q, scan_d;
  logic              pv_q, pv_d;        // a read is in flight
  logic [FAT_AW-1:0] pidx_q, pidx_d;    // index of the read in flight
  logic [CNT_W-1:0]  free_q, free_d;
  logic [CNT_W-1:0]  taken_q, taken_d;
  logic [SIZE_W-1:0] need_q, need_d;
  logic [FAT_AW-1:0] prev_q, prev_d;
  logic              rdok_q, rdok_d;

  // result word
  logic          done_q, done_d;
  logic [EW-1:0] rv_q, rv_d;
  logic [EW-1:0] fc_q, fc_d;
  logic          st_q, st_d;

  // table RAM ports
  logic              mem_we;
  logic [FAT_AW-1:0] mem_waddr;
  logic [EW-1:0]     mem_wdata;
  logic              mem_re;
  logic [FAT_AW-1:0] mem_raddr;
  logic [EW-1:0]     mem_rdata;

  // scan limit and allocation size
  logic [CNT_W-1:0]  lim;
  logic              in_range;
  logic              issue;
  logic              hit;
  logic [SIZE_W:0]   round_up;
  logic [SIZE_W:0]   size_sum;
  logic [SIZE_W-1:0] need_raw;

  fca_ram #(
    .DEPTH (FAT_ENTRIES),
    .AW    (FAT_AW),
    .DW    (EW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // saturate the scan limit to the table depth
  assign lim = (entry_count_q > CFG_W'(FAT_ENTRIES)) ? CNT_W'(FAT_ENTRIES)
                                                     : CNT_W'(entry_count_q);

  assign in_range = ({1'b0, entry_index_i} < (EW + 1)'(FAT_ENTRIES));

  // n = ceil(size / 2^shift), at least one cluster
  assign round_up = ((SIZE_W + 1)'(1) << cluster_shift_q) - (SIZE_W + 1)'(1);
  assign size_sum = {1'b0, file_size_i} + round_up;
  assign need_raw = SIZE_W'(size_sum >> cluster_shift_q);

  assign hit = pv_q && (mem_rdata == FAT_FREE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_count_q   <= ENTRY_COUNT_RST;
      cluster_shift_q <= CLUSTER_SHIFT_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_ENTRY_COUNT:   entry_count_q   <= cfg_wdata_i;
        CFG_CLUSTER_SHIFT: cluster_shift_q <= cfg_wdata_i[SHF_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      clr_q   <= '0;
      scan_q  <= '0;
      pv_q    <= 1'b0;
      free_q  <= '0;
      taken_q <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      scan_q  <= scan_d;
      pv_q    <= pv_d;
      free_q  <= free_d;
      taken_q <= taken_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pidx_q <= pidx_d;
    need_q <= need_d;
    prev_q <= prev_d;
    rdok_q <= rdok_d;
    rv_q   <= rv_d;
    fc_q   <= fc_d;
    st_q   <= st_d;
  end

  always_comb begin
    state_d   = state_q;
    clr_d     = clr_q;
    scan_d    = scan_q;
    pv_d      = 1'b0;
    pidx_d    = pidx_q;
    free_d    = free_q;
    taken_d   = taken_q;
    need_d    = need_q;
    prev_d    = prev_q;
    rdok_d    = rdok_q;
    done_d    = 1'b0;
    rv_d      = rv_q;
    fc_d      = fc_q;
    st_d      = st_q;
    mem_we    = 1'b0;
    mem_waddr = prev_q;
    mem_wdata = FAT_EOC;
    mem_re    = 1'b0;
    mem_raddr = scan_q[FAT_AW-1:0];
    issue     = 1'b0;

    case (state_q)
      ST_CLEAR: begin
        // sweep zeros through the whole table
        mem_we    = 1'b1;
        mem_waddr = clr_q;
        mem_wdata = FAT_FREE;
        clr_d     = clr_q + FAT_AW'(1);
        if (clr_q == FAT_AW'(FAT_ENTRIES - 1)) begin
          state_d = ST_IDLE;
        end
      end

      ST_IDLE: begin
        if (start) begin
          rv_d = '0;
          fc_d = '0;
          st_d = STATUS_OK;
          case (func_i)
            FUNC_WRITE: begin
              mem_we    = in_range;
              mem_waddr = entry_index_i[FAT_AW-1:0];
              mem_wdata = entry_value_i;
              done_d    = 1'b1;
            end
            FUNC_READ: begin
              mem_re    = 1'b1;
              mem_raddr = entry_index_i[FAT_AW-1:0];
              rdok_d    = in_range;
              state_d   = ST_READ;
            end
            FUNC_ALLOC: begin
              need_d  = (need_raw == '0) ? SIZE_W'(1) : need_raw;
              scan_d  = FIRST_DATA;
              free_d  = '0;
              state_d = ST_COUNT;
            end
            default: begin
              done_d = 1'b1;
            end
          endcase
        end
      end

      ST_READ: begin
        rv_d    = rdok_q ? mem_rdata : '0;
        done_d  = 1'b1;
        state_d = ST_IDLE;
      end

      ST_COUNT: begin
        // one read per cycle; count the word when it returns in the next cycle
        issue = (scan_q < lim);
        if (hit) begin
          free_d = free_q + CNT_W'(1);
        end
        if (!issue && !pv_q) begin
          if (SIZE_W'(free_q) < need_q) begin
            st_d    = STATUS_NO_SPACE;
            done_d  = 1'b1;
            state_d = ST_IDLE;
          end else begin
            scan_d  = FIRST_DATA;
            taken_d = '0;
            state_d = ST_LINK;
          end
        end
      end

      ST_LINK: begin
        if (SIZE_W'(taken_q) == need_q) begin
          // close the chain; drop any read still in flight
          mem_we    = 1'b1;
          mem_waddr = prev_q;
          mem_wdata = FAT_EOC;
          done_d    = 1'b1;
          state_d   = ST_IDLE;
        end else begin
          issue = (scan_q < lim);
          if (hit) begin
            if (taken_q == '0) begin
              fc_d = EW'(pidx_q);
            end else begin
              mem_we    = 1'b1;
              mem_waddr = prev_q;
              mem_wdata = EW'(pidx_q);
            end
            prev_d  = pidx_q;
            taken_d = taken_q + CNT_W'(1);
          end
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase

    if (issue) begin
      mem_re    = 1'b1;
      mem_raddr = scan_q[FAT_AW-1:0];
      pv_d      = 1'b1;
      pidx_d    = scan_q[FAT_AW-1:0];
      scan_d    = scan_q + CNT_W'(1);
    end
  end

  assign busy            = (state_q != ST_IDLE);
  assign done_o          = done_q;
  assign read_value_o    = rv_q;
  assign first_cluster_o = fc_q;
  assign status_o        = st_q;

endmodule

/* src/fca_ram.sv */
`timescale 1ns / 1ps

module fca_ram #(
  parameter int unsigned DEPTH = 4096,
  parameter int unsigned AW    = $clog2(DEPTH),
  parameter int unsigned DW    = 12
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [DW-1:0] wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [DW-1:0] rdata_o
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* verif/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
  import fca_pkg::*;

  // Worst allocate is two sweeps of the whole table; the run holds only a handful of those,
  // so this bound sits far above any correct run including the clearing sweep after reset.
  localparam int unsigned CYCLE_LIMIT = 2_000_000;

  typedef struct packed {
    logic [EW-1:0] read_value;
    logic [EW-1:0] first_cluster;
    logic          status;
  } answer_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              start = 1'b0;
  logic              busy;
  func_e             func_i = FUNC_NONE;
  logic [EW-1:0]     entry_index_i = '0;
  logic [EW-1:0]     entry_value_i = '0;
  logic [SIZE_W-1:0] file_size_i = '0;
  logic              done_o;
  logic [EW-1:0]     read_value_o;
  logic [EW-1:0]     first_cluster_o;
  logic              status_o;
  logic              cfg_we_i = 1'b0;
  cfg_idx_e          cfg_idx_i = CFG_ENTRY_COUNT;
  logic [CFG_W-1:0]  cfg_wdata_i = '0;

  // Private copy of the allocation table and of the two settings, advanced one command
  // at a time in the order the block accepts them.
  logic [EW-1:0]     fat_mirror [FAT_ENTRIES] = '{default: '0};
  logic [CFG_W-1:0]  entry_count_q = ENTRY_COUNT_RST;
  logic [SHF_W-1:0]  shift_q = CLUSTER_SHIFT_RST;

  answer_t           pending_answers [$];
  int                idle_pct = 0;
  int unsigned       cmd_count [4] = '{default: 0};
  int unsigned       no_space_n = 0;
  int unsigned       words_checked = 0;
  int unsigned       settings_n = 0;
  int unsigned       mismatches = 0;
  int unsigned       cycle_n = 0;

  fat12_cluster_chain_allocator u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start           (start),
    .busy            (busy),
    .func_i          (func_i),
    .entry_index_i   (entry_index_i),
    .entry_value_i   (entry_value_i),
    .file_size_i     (file_size_i),
    .done_o          (done_o),
    .read_value_o    (read_value_o),
    .first_cluster_o (first_cluster_o),
    .status_o        (status_o),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_wdata_i     (cfg_wdata_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Scans stop below entry_count, which saturates at the table size.
  function automatic int unsigned scan_limit();
    return (entry_count_q > FAT_ENTRIES) ? FAT_ENTRIES : int'(entry_count_q);
  endfunction

  // Free entries that an allocate may hand out: reserved entries 0 and 1 never count.
  function automatic int unsigned free_entries();
    int unsigned n;
    n = 0;
    for (int unsigned i = 2; i < scan_limit(); i++)
      if (fat_mirror[i] == FAT_FREE) n++;
    return n;
  endfunction

  // Apply one accepted command to the mirror and return the word the block must answer.
  function automatic answer_t fat_execute(func_e f, logic [EW-1:0] idx, logic [EW-1:0] val,
                                          logic [SIZE_W-1:0] size);
    answer_t     a;
    logic [33:0] need;
    int unsigned taken;
    int unsigned prev;
    a = '0;
    taken = 0;
    prev = 0;
    case (f)
      FUNC_WRITE: begin
        fat_mirror[idx] = val;
      end
      FUNC_READ: begin
        a.read_value = fat_mirror[idx];
      end
      FUNC_ALLOC: begin
        // Round the size up to whole clusters; an empty file still takes one.
        need = ({2'b00, size} + (34'd1 << shift_q) - 34'd1) >> shift_q;
        if (need == 0) need = 1;
        if (34'(free_entries()) < need) begin
          a.status = STATUS_NO_SPACE;
          no_space_n++;
        end else begin
          // Link the first free entries in ascending order, close with end of chain.
          for (int unsigned i = 2; i < scan_limit() && 34'(taken) < need; i++) begin
            if (fat_mirror[i] == FAT_FREE) begin
              if (taken == 0) a.first_cluster = EW'(i);
              else fat_mirror[prev] = EW'(i);
              prev = i;
              taken++;
            end
          end
          fat_mirror[prev] = FAT_EOC;
        end
      end
      default: begin
      end
    endcase
    return a;
  endfunction

  // Present one command, hold it until the block takes it, then queue its answer.
  // Start stays high on return so back-to-back commands need no second drive.
  task automatic send_command(func_e f, logic [EW-1:0] idx, logic [EW-1:0] val,
                              logic [SIZE_W-1:0] size);
    while ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start         <= 1'b1;
    func_i        <= f;
    entry_index_i <= idx;
    entry_value_i <= val;
    file_size_i   <= size;
    do @(posedge clk_i); while (busy);
    pending_answers.push_back(fat_execute(f, idx, val, size));
    cmd_count[f]++;
  endtask

  // Drop start and wait until every answer is in and the block has gone idle.
  task automatic settle();
    start <= 1'b0;
    while (pending_answers.size() != 0 || busy) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Reprogram both registers while idle; the shift word may carry junk above bit 3.
  task automatic write_settings(logic [CFG_W-1:0] count_word, logic [CFG_W-1:0] shift_word);
    settle();
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= CFG_ENTRY_COUNT;
    cfg_wdata_i <= count_word;
    @(posedge clk_i);
    cfg_idx_i   <= CFG_CLUSTER_SHIFT;
    cfg_wdata_i <= shift_word;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    entry_count_q = count_word;
    shift_q       = shift_word[SHF_W-1:0];
    settings_n++;
  endtask

  // After the clearing sweep every entry reads zero, at both ends and in the middle.
  task automatic test_reset_state();
    send_command(FUNC_READ, 12'h000, 12'h000, 32'h0);
    send_command(FUNC_READ, 12'hFFF, 12'hFFF, 32'hFFFF_FFFF);
    send_command(FUNC_READ, 12'h801, 12'h000, 32'h0);
  endtask

  // Plain table access, including the reserved entries and the unused function code.
  task automatic test_entry_access();
    send_command(FUNC_WRITE, 12'hFFF, 12'hFFF, 32'h0);
    send_command(FUNC_READ,  12'hFFF, 12'h000, 32'h0);
    send_command(FUNC_WRITE, 12'h000, 12'hABC, 32'h0);
    send_command(FUNC_READ,  12'h000, 12'h000, 32'h0);
    send_command(FUNC_WRITE, 12'h001, 12'h001, 32'h0);
    send_command(FUNC_READ,  12'h001, 12'h000, 32'h0);
    send_command(FUNC_NONE,  12'hFFF, 12'hFFF, 32'hFFFF_FFFF);
    send_command(FUNC_WRITE, 12'h7D0, 12'h5A5, 32'h0);
    send_command(FUNC_READ,  12'h7D0, 12'h000, 32'h0);
  endtask

  // Size rounding, exact fit, out of space, tiny scan windows and a saturated count.
  task automatic test_allocate_edges();
    // Empty file over the whole table takes one cluster.
    send_command(FUNC_ALLOC, 12'h000, 12'h000, 32'h0);
    // Byte-sized clusters in a 16-entry window: fill it exactly, then ask for one more.
    write_settings(13'd16, 13'd0);
    send_command(FUNC_ALLOC, 12'h000, 12'h000, 32'(free_entries()));
    send_command(FUNC_ALLOC, 12'h000, 12'h000, 32'd1);
    send_command(FUNC_WRITE, 12'h005, FAT_FREE, 32'h0);
    send_command(FUNC_ALLOC, 12'h000, 12'h000, 32'd1);
    // Window holds only the reserved entries: nothing can be free.
    write_settings(13'd2, 13'd15);
    send_command(FUNC_ALLOC, 12'h000, 12'h000, 32'h0);
    // One usable entry with the largest clusters: one cluster exactly fits, one byte over fails.
    write_settings(13'd3, 13'd15);
    send_command(FUNC_WRITE, 12'h002, FAT_FREE, 32'h0);
    send_command(FUNC_ALLOC, 12'h000, 12'h000, 32'd32768);
    send_command(FUNC_WRITE, 12'h002, FAT_FREE, 32'h0);
    send_command(FUNC_ALLOC, 12'h000, 12'h000, 32'd32769);
    send_command(FUNC_ALLOC, 12'h000, 12'h000, 32'hFFFF_FFFF);
    // Count beyond the table clamps to the full table.
    write_settings(13'h1FFF, 13'h1FF9);
    send_command(FUNC_ALLOC, 12'h000, 12'h000, 32'd1536);
  endtask

  // Mixed traffic in one setting: writes mostly free or occupy entries inside the window,
  // and allocate sizes are mostly aimed just around the free count so both outcomes occur.
  task automatic test_random_traffic(int pct, logic [CFG_W-1:0] count_word,
                                     logic [SHF_W-1:0] shift, int items);
    int unsigned lim;
    int unsigned pick;
    int unsigned need_n;
    logic [EW-1:0]     idx;
    logic [SIZE_W-1:0] size;
    write_settings(count_word, {9'($urandom_range(0, 511)), shift});
    idle_pct = pct;
    lim = scan_limit();
    repeat (items) begin
      pick = $urandom_range(0, 99);
      idx = ($urandom_range(0, 3) != 0) ? EW'($urandom_range(0, lim + 1)) : EW'($urandom);
      if (pick < 30) begin
        send_command(FUNC_WRITE, idx, ($urandom_range(0, 1) != 0) ? FAT_FREE : EW'($urandom),
                     $urandom);
      end else if (pick < 55) begin
        send_command(FUNC_READ, idx, EW'($urandom), $urandom);
      end else if (pick < 95) begin
        case ($urandom_range(0, 9))
          0: size = '0;
          1: size = $urandom;
          default: begin
            need_n = $urandom_range(1, free_entries() + 1);
            size = (SIZE_W'(need_n - 1) << shift) + SIZE_W'($urandom_range(1, 1 << shift));
          end
        endcase
        send_command(FUNC_ALLOC, EW'($urandom), EW'($urandom), size);
      end else begin
        send_command(FUNC_NONE, EW'($urandom), EW'($urandom), $urandom);
      end
    end
  endtask

  // Every done_o pulse carries one word; match it against the oldest open command.
  always @(posedge clk_i) begin : check_words
    answer_t want;
    if (rst_ni && done_o === 1'b1) begin
      if (pending_answers.size() == 0) begin
        $display("%0t: word with no command open: expected none, got rd=%03h first=%03h st=%0b",
                 $time, read_value_o, first_cluster_o, status_o);
        mismatches++;
      end else begin
        want = pending_answers.pop_front();
        words_checked++;
        if (read_value_o !== want.read_value) begin
          $display("%0t: read_value expected %03h got %03h",
                   $time, want.read_value, read_value_o);
          mismatches++;
        end
        if (first_cluster_o !== want.first_cluster) begin
          $display("%0t: first_cluster expected %03h got %03h",
                   $time, want.first_cluster, first_cluster_o);
          mismatches++;
        end
        if (status_o !== want.status) begin
          $display("%0t: status expected %0b got %0b", $time, want.status, status_o);
          mismatches++;
        end
      end
    end
  end

  // Hard stop if the block hangs.
  always @(posedge clk_i) begin
    cycle_n++;
    if (cycle_n > CYCLE_LIMIT) begin
      $display("fat12_cluster_chain_allocator verification failed");
      $finish;
    end
  end

  initial begin
    // Hold reset, release it, then let the clearing sweep finish.
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);
    settle();

    idle_pct = 19;
    test_reset_state();
    test_entry_access();
    test_allocate_edges();

    test_random_traffic(19, 13'd24, 4'd0, 13);
    test_random_traffic(19, 13'($urandom_range(3, 40)), 4'd15, 13);
    test_random_traffic(62, 13'($urandom_range(3, 40)), 4'($urandom_range(0, 15)), 13);
    test_random_traffic(62, 13'd3, 4'($urandom_range(0, 15)), 13);
    test_random_traffic(0, 13'd4096, 4'($urandom_range(0, 15)), 12);
    test_random_traffic(0, 13'($urandom_range(3, 64)), 4'($urandom_range(0, 15)), 13);

    // Drain the last words, then give the block a little longer to misbehave.
    start <= 1'b0;
    while (pending_answers.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);

    $display("Ran %0d writes, %0d reads, %0d allocates (%0d short of space), %0d unused codes",
             cmd_count[FUNC_WRITE], cmd_count[FUNC_READ], cmd_count[FUNC_ALLOC], no_space_n,
             cmd_count[FUNC_NONE]);
    $display("Checked %0d words over %0d register settings in %0d cycles, %0d mismatches",
             words_checked, settings_n, cycle_n, mismatches);
    if (mismatches == 0 && pending_answers.size() == 0) begin
      $display("fat12_cluster_chain_allocator verification clean");
    end else begin
      $display("fat12_cluster_chain_allocator verification failed");
    end
    $finish;
  end

endmodule
